### src/rpwd_pkg.sv
// shared types, constants and mapping helpers for the rc pulse width decoder
`default_nettype none

package rpwd_pkg;

    localparam int TIME_BITS   = 32;
    localparam int TIMEOUT_W   = 20;
    localparam int WIN_W       = 16;
    localparam int JUMP_W      = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int PW_W        = 17;
    localparam int MAP_BITS    = 16;
    localparam int VAL_W       = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = TIMEOUT_W'(60000);
    localparam logic [WIN_W-1:0]     VALID_MIN_RST = WIN_W'(900);
    localparam logic [WIN_W-1:0]     VALID_MAX_RST = WIN_W'(2100);
    localparam logic [JUMP_W-1:0]    JUMP_RST      = JUMP_W'(30);
    localparam logic [PW_W-1:0]      PRIOR_CLAMP   = PW_W'(100000);

    // 2^18 / 5 rounded up, exact for magnitudes below 2^17
    localparam logic [16:0] RECIP_FIVE = 17'd52429;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_VALID_MIN = 2'd1,
        CFG_VALID_MAX = 2'd2,
        CFG_JUMP      = 2'd3
    } cfg_idx_t;

    typedef logic signed [MAP_BITS-1:0] map_t;

    // widths after edge handling, ready for mapping
    typedef struct packed {
        logic            lost;
        logic            steer_ok;
        logic            motor_ok;
        logic [PW_W-1:0] steer_w;
        logic [PW_W-1:0] motor_w;
        logic [PW_W-1:0] prior_w;
    } width_beat_t;

    // mapped values awaiting the jump test
    typedef struct packed {
        logic lost;
        logic steer_ok;
        logic motor_ok;
        map_t steer_m;
        map_t motor_m;
        map_t prior_m;
    } map_beat_t;

    // (w - 1000) / 5 truncated toward zero, minus 100
    function automatic map_t map_width(input logic [PW_W-1:0] w);
        logic signed [PW_W:0] diff;
        logic [PW_W-1:0]      mag;
        logic [33:0]          prod;
        map_t                 q;
        diff = $signed({1'b0, w}) - 18'sd1000;
        mag  = diff[PW_W] ? PW_W'(-diff) : diff[PW_W-1:0];
        prod = 34'(mag) * 34'(RECIP_FIVE);
        q    = $signed({1'b0, prod[32:18]});
        if (diff[PW_W])
        begin
            q = -q;
        end
        return q - 16'sd100;
    endfunction

    function automatic logic [VAL_W-1:0] sat8(input map_t v);
        logic [VAL_W-1:0] r;
        if (v > 16'sd127)
        begin
            r = 8'h7f;
        end
        else if (v < -16'sd128)
        begin
            r = 8'h80;
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/rc_pulse_width_decoder.sv
// rc receiver pulse width decoder: edge timing, window check, mapping and jump filter
`default_nettype none

// a read beat passes the input register, width stage, mapping stage and output
// register before it appears on the master side
// throughput: one beat per cycle while m_tready does not hold the pipe, which never loops back on itself
// beats without a read request update the timing state and give no output beat
// reset (rst_n low, asynchronous) clears all timing state and loads the default
// configuration: timeout 60000, window 900..2100, jump limit 30
module rc_pulse_width_decoder
    import rpwd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // slave side
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [0] motor_level, [1] steer_level,
                                                   // [2] read_request, rest zero
    // master side
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata    // [7:0] steering_value, [15:8] motor_value,
                                                   // [16] signal_lost, rest zero
);

    // configuration registers
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [WIN_W-1:0]     valid_min_reg;
    logic [WIN_W-1:0]     valid_max_reg;
    logic [JUMP_W-1:0]    jump_reg;

    // timing state
    logic [TIME_BITS-1:0] time_reg;
    logic                 prev_motor_reg;
    logic                 prev_steer_reg;
    logic [TIME_BITS-1:0] motor_rise_reg;
    logic [TIME_BITS-1:0] steer_rise_reg;
    logic [TIME_BITS-1:0] motor_width_reg;
    logic [TIME_BITS-1:0] prior_width_reg;
    logic [TIME_BITS-1:0] steer_width_reg;
    logic [TIME_BITS-1:0] last_edge_reg;

    // pipe stage 1: input beat with its timestamp
    logic                 s1_valid_reg;
    logic                 s1_motor_reg;
    logic                 s1_steer_reg;
    logic                 s1_read_reg;
    logic [TIME_BITS-1:0] s1_now_reg;

    // pipe stage 2: widths, stage 3: mapped values, then the output register
    logic        s2_valid_reg;
    width_beat_t s2_reg;
    width_beat_t s2_next;
    logic        s3_valid_reg;
    map_beat_t   s3_reg;
    map_beat_t   s3_next;
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TDATA_W-1:0] m_data_next;

    // flow control: each stage moves when the one after it is empty or moving
    logic out_free;
    logic s3_adv;
    logic s3_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic s1_free;
    logic in_acc;

    assign out_free = !m_valid_reg || m_tready;
    assign s3_adv   = s3_valid_reg && out_free;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_adv   = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_acc   = s_tvalid && s1_free;

    assign s_tready = s1_free;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // edge handling on the stage 1 beat
    logic                 motor_edge;
    logic                 steer_edge;
    logic                 motor_rise;
    logic                 motor_fall;
    logic                 steer_rise;
    logic                 steer_fall;
    logic [TIME_BITS-1:0] motor_width_next;
    logic [TIME_BITS-1:0] prior_width_next;
    logic [TIME_BITS-1:0] steer_width_next;
    logic [TIME_BITS-1:0] last_edge_next;
    logic [TIME_BITS-1:0] elapsed;

    assign motor_edge = s1_motor_reg != prev_motor_reg;
    assign steer_edge = s1_steer_reg != prev_steer_reg;
    assign motor_rise = motor_edge && s1_motor_reg;
    assign motor_fall = motor_edge && !s1_motor_reg;
    assign steer_rise = steer_edge && s1_steer_reg;
    assign steer_fall = steer_edge && !s1_steer_reg;

    always_comb
    begin
        motor_width_next = motor_width_reg;
        prior_width_next = prior_width_reg;
        steer_width_next = steer_width_reg;
        last_edge_next   = last_edge_reg;
        if (motor_fall)
        begin
            // the old width is kept for the jump filter
            prior_width_next = motor_width_reg;
            motor_width_next = s1_now_reg - motor_rise_reg;
        end
        if (steer_fall)
        begin
            steer_width_next = s1_now_reg - steer_rise_reg;
        end
        if (motor_edge || steer_edge)
        begin
            last_edge_next = s1_now_reg;
        end
    end

    // read evaluation sees the state after this beat's edges
    assign elapsed = s1_now_reg - last_edge_next;

    always_comb
    begin
        s2_next.lost     = elapsed > TIME_BITS'(timeout_reg);
        s2_next.steer_ok = !s2_next.lost
                           && steer_width_next >= TIME_BITS'(valid_min_reg)
                           && steer_width_next <= TIME_BITS'(valid_max_reg);
        s2_next.motor_ok = !s2_next.lost
                           && motor_width_next >= TIME_BITS'(valid_min_reg)
                           && motor_width_next <= TIME_BITS'(valid_max_reg);
        // valid widths fit the 16-bit window, so the low bits suffice
        s2_next.steer_w  = {1'b0, steer_width_next[WIN_W-1:0]};
        s2_next.motor_w  = {1'b0, motor_width_next[WIN_W-1:0]};
        // prior width is mapped whether valid or not, clamped first
        if (prior_width_next > TIME_BITS'(PRIOR_CLAMP))
        begin
            s2_next.prior_w = PRIOR_CLAMP;
        end
        else
        begin
            s2_next.prior_w = prior_width_next[PW_W-1:0];
        end
    end

    // stage 3: linear mapping, one multiplier per value
    always_comb
    begin
        s3_next.lost     = s2_reg.lost;
        s3_next.steer_ok = s2_reg.steer_ok;
        s3_next.motor_ok = s2_reg.motor_ok;
        s3_next.steer_m  = map_width(s2_reg.steer_w);
        s3_next.motor_m  = map_width(s2_reg.motor_w);
        s3_next.prior_m  = map_width(s2_reg.prior_w);
    end

    // output stage: jump filter on exact values, then saturation
    logic signed [MAP_BITS+1:0] motor_x;
    logic signed [MAP_BITS+1:0] prior_x;
    logic signed [MAP_BITS+1:0] jump_x;
    logic                       jumped;
    map_t                       steer_fin;
    map_t                       motor_fin;

    always_comb
    begin
        motor_x = {{2{s3_reg.motor_m[MAP_BITS-1]}}, s3_reg.motor_m};
        prior_x = {{2{s3_reg.prior_m[MAP_BITS-1]}}, s3_reg.prior_m};
        jump_x  = $signed({{(MAP_BITS+2-JUMP_W){1'b0}}, jump_reg});
        // positive values may not rise too far above the prior, others may not fall too far below it
        if (motor_x > 18'sd0)
        begin
            jumped = prior_x < (motor_x - jump_x);
        end
        else
        begin
            jumped = prior_x > (motor_x + jump_x);
        end
        steer_fin = s3_reg.steer_ok ? s3_reg.steer_m : '0;
        motor_fin = (s3_reg.motor_ok && !jumped) ? s3_reg.motor_m : '0;
        m_data_next = {7'd0, s3_reg.lost, sat8(motor_fin), sat8(steer_fin)};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RST;
            valid_min_reg   <= VALID_MIN_RST;
            valid_max_reg   <= VALID_MAX_RST;
            jump_reg        <= JUMP_RST;
            time_reg        <= '0;
            prev_motor_reg  <= 1'b0;
            prev_steer_reg  <= 1'b0;
            motor_rise_reg  <= '0;
            steer_rise_reg  <= '0;
            motor_width_reg <= '0;
            prior_width_reg <= '0;
            steer_width_reg <= '0;
            last_edge_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TIMEOUT:   timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                    CFG_VALID_MIN: valid_min_reg <= cfg_data[WIN_W-1:0];
                    CFG_VALID_MAX: valid_max_reg <= cfg_data[WIN_W-1:0];
                    CFG_JUMP:      jump_reg      <= cfg_data[JUMP_W-1:0];
                    default:       jump_reg      <= jump_reg;
                endcase
            end

            // one tick per accepted beat
            if (in_acc)
            begin
                time_reg <= time_reg + 1'b1;
            end

            // timing state moves as a beat leaves stage 1
            if (s1_adv)
            begin
                prev_motor_reg  <= s1_motor_reg;
                prev_steer_reg  <= s1_steer_reg;
                motor_width_reg <= motor_width_next;
                prior_width_reg <= prior_width_next;
                steer_width_reg <= steer_width_next;
                last_edge_reg   <= last_edge_next;
                if (motor_rise)
                begin
                    motor_rise_reg <= s1_now_reg;
                end
                if (steer_rise)
                begin
                    steer_rise_reg <= s1_now_reg;
                end
            end

            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // beats without a read drop out here
            if (s1_adv)
            begin
                s2_valid_reg <= s1_read_reg;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_adv)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (s3_adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_motor_reg <= s_tdata[0];
            s1_steer_reg <= s_tdata[1];
            s1_read_reg  <= s_tdata[2];
            s1_now_reg   <= time_reg;
        end
        if (s1_adv)
        begin
            s2_reg <= s2_next;
        end
        if (s2_adv)
        begin
            s3_reg <= s3_next;
        end
        if (s3_adv)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// testbench for the rc pulse width decoder: tick stimulus, command scoreboard and stall control
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpwd_pkg::*;

    // run guard, generous against the slowest legal run (every tick a read under heavy stalls)
    localparam int unsigned CYCLE_LIMIT     = 200000;
    // prior motor widths beyond this are capped before mapping
    localparam int unsigned PRIOR_WIDTH_CAP = 100000;
    // quiet cycles after the last expected beat, well past the 4-stage pipe
    localparam int unsigned DRAIN_CYCLES    = 8;

    // one decoded command as it leaves the block, steering in the lowest byte
    typedef struct packed {
        logic             lost;
        logic [VAL_W-1:0] motor;
        logic [VAL_W-1:0] steer;
    } rc_cmd_t;

    // pulse timing predictor plus the queue of commands still owed by the block
    class rc_scoreboard;
        logic [TIMEOUT_W-1:0] timeout;
        logic [WIN_W-1:0]     win_lo;
        logic [WIN_W-1:0]     win_hi;
        logic [JUMP_W-1:0]    jump;

        logic [TIME_BITS-1:0] now_t;
        logic [TIME_BITS-1:0] motor_rise;
        logic [TIME_BITS-1:0] steer_rise;
        logic [TIME_BITS-1:0] motor_w;
        logic [TIME_BITS-1:0] motor_w_prior;
        logic [TIME_BITS-1:0] steer_w;
        logic [TIME_BITS-1:0] last_edge;
        logic                 motor_prev;
        logic                 steer_prev;
        logic                 lost;

        rc_cmd_t              cmd_queue[$];
        int unsigned          errors;

        function new();
            errors = 0;
            timeout = TIMEOUT_RST;
            win_lo = VALID_MIN_RST;
            win_hi = VALID_MAX_RST;
            jump = JUMP_RST;
            now_t = '0;
            motor_rise = '0;
            steer_rise = '0;
            motor_w = '0;
            motor_w_prior = '0;
            steer_w = '0;
            last_edge = '0;
            motor_prev = 1'b0;
            steer_prev = 1'b0;
            lost = 1'b0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TIMEOUT:   timeout = val[TIMEOUT_W-1:0];
                CFG_VALID_MIN: win_lo = val[WIN_W-1:0];
                CFG_VALID_MAX: win_hi = val[WIN_W-1:0];
                CFG_JUMP:      jump = val[JUMP_W-1:0];
                default:       ;
            endcase
        endfunction

        // exact (w - 1000) * 200 / 1000 - 100, quotient truncated toward zero
        function longint width_to_cmd(logic [TIME_BITS-1:0] w);
            longint x;
            x = longint'({32'd0, w});
            return ((x - 1000) * 200) / 1000 - 100;
        endfunction

        function bit in_window(logic [TIME_BITS-1:0] w);
            return (w >= win_lo) && (w <= win_hi);
        endfunction

        function logic [VAL_W-1:0] clip8(longint v);
            if (v > 127)
                v = 127;
            if (v < -128)
                v = -128;
            return v[VAL_W-1:0];
        endfunction

        // one accepted tick: edges first, then the read at the same time, then time moves on
        function void note_tick(logic [2:0] bits);
            logic                 mlvl;
            logic                 slvl;
            logic                 rd;
            logic [TIME_BITS-1:0] gap;
            logic [TIME_BITS-1:0] prior_w;
            longint               steer_cmd;
            longint               motor_cmd;
            longint               prior_cmd;
            rc_cmd_t              c;
            mlvl = bits[0];
            slvl = bits[1];
            rd = bits[2];
            if (mlvl != motor_prev)
            begin
                if (mlvl)
                    motor_rise = now_t;
                else
                begin
                    motor_w_prior = motor_w;
                    motor_w = now_t - motor_rise;
                end
                last_edge = now_t;
            end
            if (slvl != steer_prev)
            begin
                if (slvl)
                    steer_rise = now_t;
                else
                    steer_w = now_t - steer_rise;
                last_edge = now_t;
            end
            motor_prev = mlvl;
            steer_prev = slvl;
            if (rd)
            begin
                steer_cmd = 0;
                motor_cmd = 0;
                gap = now_t - last_edge;
                if (gap > timeout)
                    lost = 1'b1;
                else
                begin
                    lost = 1'b0;
                    if (in_window(steer_w))
                        steer_cmd = width_to_cmd(steer_w);
                    if (in_window(motor_w))
                    begin
                        prior_w = (motor_w_prior > PRIOR_WIDTH_CAP) ? PRIOR_WIDTH_CAP
                                                                    : motor_w_prior;
                        prior_cmd = width_to_cmd(prior_w);
                        motor_cmd = width_to_cmd(motor_w);
                        if (motor_cmd > 0)
                        begin
                            if (prior_cmd < motor_cmd - longint'(jump))
                                motor_cmd = 0;
                        end
                        else if (prior_cmd > motor_cmd + longint'(jump))
                            motor_cmd = 0;
                    end
                end
                c.steer = clip8(steer_cmd);
                c.motor = clip8(motor_cmd);
                c.lost = lost;
                cmd_queue.push_back(c);
            end
            now_t = now_t + 1'b1;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            rc_cmd_t want;
            if (cmd_queue.size() == 0)
            begin
                errors++;
                $error("unexpected command beat %h", beat);
                return;
            end
            want = cmd_queue.pop_front();
            if (beat[7:0] !== want.steer)
            begin
                errors++;
                $error("steering_value: expected %0d, got %0d",
                       $signed(want.steer), $signed(beat[7:0]));
            end
            if (beat[15:8] !== want.motor)
            begin
                errors++;
                $error("motor_value: expected %0d, got %0d",
                       $signed(want.motor), $signed(beat[15:8]));
            end
            if (beat[16] !== want.lost)
            begin
                errors++;
                $error("signal_lost: expected %0d, got %0d", want.lost, beat[16]);
            end
        endfunction
    endclass

    // every block input starts at a known value
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    rc_scoreboard board = new();

    // idling knobs, percent per cycle
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // long receiver hold-off, raised by its own timer process
    logic        hold_off       = 1'b0;
    int unsigned cycle_count    = 0;

    // pin waveform generator for the short random phases
    logic        motor_lvl  = 1'b0;
    logic        steer_lvl  = 1'b0;
    int unsigned motor_left = 0;
    int unsigned steer_left = 0;

    rc_pulse_width_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] motor_level, [1] steer_level, [2] read_request
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // [7:0] steering_value, [15:8] motor_value, [16] signal_lost
    );

    always #6 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL rc_pulse_width_decoder");
            $finish;
        end
    end

    // receiver: random stalls, forced low while a hold-off is running
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // beat monitors, sampling the values that stood before the edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_tick(s_tdata[2:0]);
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // one tick beat, with random idle cycles in front of it
    task automatic send_beat(logic motor, logic steer, logic rd);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'({rd, steer, motor});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait for every owed command, then let the pipe run empty
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (board.cmd_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] t, logic [CFG_DATA_W-1:0] lo,
                             logic [CFG_DATA_W-1:0] hi, logic [CFG_DATA_W-1:0] j);
        write_reg(CFG_TIMEOUT, t);
        write_reg(CFG_VALID_MIN, lo);
        write_reg(CFG_VALID_MAX, hi);
        write_reg(CFG_JUMP, j);
    endtask

    // next level duration: short pulses, short gaps, the odd glitch and the odd quiet spell
    function automatic int unsigned next_len(logic lvl);
        if ($urandom_range(9, 0) == 0)
            return 1;
        if (lvl)
            return $urandom_range(90, 1);
        if ($urandom_range(24, 0) == 0)
            return $urandom_range(160, 60);
        return $urandom_range(30, 1);
    endfunction

    task automatic run_random_ticks(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (motor_left == 0)
            begin
                motor_lvl = !motor_lvl;
                motor_left = next_len(motor_lvl);
            end
            if (steer_left == 0)
            begin
                steer_lvl = !steer_lvl;
                steer_left = next_len(steer_lvl);
            end
            motor_left--;
            steer_left--;
            send_beat(motor_lvl, steer_lvl, $urandom_range(2, 0) == 0);
        end
    endtask

    // both pins rise together after a low lead-in, each falls after its own length;
    // a read lands on every falling tick and now and then in between
    task automatic send_pulse_pair(int unsigned motor_len, int unsigned steer_len,
                                   int unsigned read_gap);
        int unsigned span;
        int unsigned lead;
        span = (motor_len > steer_len) ? motor_len : steer_len;
        lead = $urandom_range(60, 20);
        for (int unsigned i = 0; i < lead; i++)
            send_beat(1'b0, 1'b0, $urandom_range(read_gap - 1, 0) == 0);
        for (int unsigned i = 0; i < span; i++)
            send_beat(i < motor_len, i < steer_len,
                      (i == motor_len) || (i == steer_len) ||
                      ($urandom_range(read_gap - 1, 0) == 0));
        send_beat(1'b0, 1'b0, 1'b1);
        motor_lvl = 1'b0;
        steer_lvl = 1'b0;
    endtask

    // short-pulse settings: windows in the tens of ticks, with the extremes on chosen phases
    task automatic setup_short_phase(int k);
        logic [CFG_DATA_W-1:0] t;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] j;
        t = CFG_DATA_W'($urandom_range(60, 1));
        lo = CFG_DATA_W'($urandom_range(40, 0));
        hi = CFG_DATA_W'($urandom_range(90, 32'(lo)));
        j = CFG_DATA_W'($urandom_range(12, 0));
        case (k)
            0:
            begin
                // tightest timeout, widest window, no jump allowance
                t = 20'd1;
                lo = 20'd0;
                hi = 20'd65535;
                j = 20'd0;
            end
            1:
            begin
                // inverted window, largest jump allowance
                lo = CFG_DATA_W'($urandom_range(90, 41));
                hi = CFG_DATA_W'($urandom_range(40, 0));
                j = 20'd255;
            end
            2:  t = 20'd1000000;
            5:  hi = lo;
            default: ;
        endcase
        write_all(t, lo, hi, j);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // default settings straight after reset
        send_beat(1'b0, 1'b0, 1'b1);   // read at time zero, nothing measured yet
        send_beat(1'b1, 1'b1, 1'b1);   // both rise on a read tick
        send_beat(1'b0, 1'b0, 1'b1);   // one-tick pulses, below the window
        send_beat(1'b0, 1'b0, 1'b0);
        send_beat(1'b0, 1'b0, 1'b1);
        drain_block();

        // timeout of one tick, full window, zero jump allowance
        write_all(20'd1, 20'd0, 20'd65535, 20'd0);
        send_beat(1'b1, 1'b0, 1'b0);
        send_beat(1'b1, 1'b1, 1'b0);
        send_beat(1'b0, 1'b1, 1'b1);   // motor falls, read on the edge
        send_beat(1'b0, 1'b0, 1'b1);   // steering falls
        send_beat(1'b0, 1'b0, 1'b1);   // one tick since the edge, still alive
        send_beat(1'b0, 1'b0, 1'b1);   // two ticks, signal lost
        send_beat(1'b0, 1'b0, 1'b1);
        send_beat(1'b1, 1'b0, 1'b1);   // fresh edge clears the lost flag
        drain_block();

        // inverted window, a long timeout and the largest jump allowance
        write_all(20'd1000000, 20'd5, 20'd4, 20'd255);
        send_beat(1'b0, 1'b0, 1'b1);
        send_beat(1'b0, 1'b1, 1'b0);
        send_beat(1'b0, 1'b0, 1'b1);
        send_beat(1'b1, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0, 1'b1);
        drain_block();

        // short random pulses over every idling mode
        for (int k = 0; k < 8; k++)
        begin
            setup_short_phase(k);
            case (k % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 86;
                end
                default:
                begin
                    send_idle_pct = 12;
                    recv_stall_pct <= 12;
                end
            endcase
            if (k == 0)
            begin
                // receiver holds off while the sender keeps offering, so the pipe backs up
                fork
                    begin
                        repeat (20) @(posedge clk);
                        hold_off <= 1'b1;
                        repeat (150) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            run_random_ticks(60);
            drain_block();
        end

        // servo-length pulses into the low end of the unsaturated mapping
        send_idle_pct = 12;
        recv_stall_pct <= 12;
        write_all(20'd1000000, CFG_DATA_W'($urandom_range(1000, 850)),
                  CFG_DATA_W'($urandom_range(2150, 2000)),
                  CFG_DATA_W'($urandom_range(60, 0)));
        send_pulse_pair($urandom_range(1050, 860), $urandom_range(1050, 860), 64);
        drain_block();

        if (board.errors == 0 && board.cmd_queue.size() == 0)
            $display("PASS rc_pulse_width_decoder");
        else
            $display("FAIL rc_pulse_width_decoder");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/rpwd_pkg.sv
src/rc_pulse_width_decoder.sv
tb/sv/tb_top.sv
